[rtl/box_contact_tracker_macros.svh]
// ----------------------------------------------------------------------------
// box contact tracker assertion macros
// immediate-consequence and next-cycle properties on clk_i / rst_ni
// ----------------------------------------------------------------------------
`ifndef BOX_CONTACT_TRACKER_MACROS_SVH
`define BOX_CONTACT_TRACKER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bct_pkg.sv]
// ----------------------------------------------------------------------------
// bct_pkg
// types and codes shared by the box contact tracker
// ----------------------------------------------------------------------------
package bct_pkg;

  localparam int unsigned BOX_W   = 5;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned SIZE_W  = 12;
  localparam int unsigned THR_W   = 16;

  localparam logic [THR_W-1:0] Z_THR_RESET = 16'd25;

  // request kinds on s_axis_tuser
  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_CHECK   = 2'd1;
  localparam logic [1:0] MODE_DISABLE = 2'd2;

  // event kinds on m_axis_tuser
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_ENTER = 2'd1;
  localparam logic [1:0] EV_EXIT  = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
  } geom_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WRB,
    ST_DIS_LOAD,
    ST_DIS_SCAN,
    ST_DIS_RMW
  } state_e;

endpackage

[rtl/box_contact_tracker.sv]
// ----------------------------------------------------------------------------
// box_contact_tracker
// box table and pairwise contact matrix with enter / exit reporting
// ----------------------------------------------------------------------------
// s_axis carries one request per transaction: tuser selects write box, check
// pair or disable box, tdata carries indexes and geometry. m_axis returns
// events: tuser is the event kind, tdata the box pair, tlast marks the final
// event of a request. cfg_* writes the depth threshold (reset value 25).
// A write gives no event. A check reads both boxes and both contact rows
// from the memories, evaluates in the next cycle and then gives one event;
// when the contact state changes it also passes through ST_WRB, since the
// two symmetric rows go through the single write port one after the other.
// A disable of an active box reads its row, clears it, then walks box
// indexes one a cycle until no partner is left, stopping at each partner for
// a read-modify-write of that partner's row, which waits while the output
// register is full and gives one exit event.
// Requests are taken one at a time, in the idle state only. Events wait in an
// output register; while the receiver stalls, the block holds at the next
// event. Reset clears all active flags and the contact matrix (row valid
// bits) at once; geometry is not cleared.
// ----------------------------------------------------------------------------
`include "box_contact_tracker_macros.svh"

module box_contact_tracker
  import bct_pkg::*;
#(
  parameter int unsigned NUM_BOXES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // box_a[4:0], box_b[9:5], pos_x[25:10], pos_y[41:26], pos_z[57:42],
  // size_w[69:58], size_h[81:70], active_flag[82], zero [87:83]
  input  logic [87:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  // event stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // first_box[4:0], second_box[9:5], zero [15:10]
  output logic [15:0] m_axis_tdata,
  // event_res[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int unsigned IDX_W = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
  localparam logic [6:0] NB7 = 7'(NUM_BOXES);
  localparam logic [NUM_BOXES-1:0] ROW_ONE = NUM_BOXES'(1);

  // request fields
  logic [BOX_W-1:0]   in_box_a;
  logic [BOX_W-1:0]   in_box_b;
  geom_t              in_geom;
  logic               in_active;
  logic [6:0]         a_ext;
  logic [6:0]         b_ext;
  logic [IDX_W-1:0]   a_idx;
  logic [IDX_W-1:0]   b_idx;
  logic               a_rng;
  logic               b_rng;
  logic               in_hs;

  assign in_box_a  = s_axis_tdata[4:0];
  assign in_box_b  = s_axis_tdata[9:5];
  assign in_geom.x = s_axis_tdata[25:10];
  assign in_geom.y = s_axis_tdata[41:26];
  assign in_geom.z = s_axis_tdata[57:42];
  assign in_geom.w = s_axis_tdata[69:58];
  assign in_geom.h = s_axis_tdata[81:70];
  assign in_active = s_axis_tdata[82];

  assign a_ext = 7'(in_box_a);
  assign b_ext = 7'(in_box_b);
  assign a_idx = a_ext[IDX_W-1:0];
  assign b_idx = b_ext[IDX_W-1:0];
  assign a_rng = (a_ext < NB7);
  assign b_rng = (b_ext < NB7);

  state_e state_q, state_d;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_hs         = s_axis_tvalid && s_axis_tready;

  // threshold register
  logic [THR_W-1:0] z_thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_thr_q <= Z_THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      z_thr_q <= cfg_data_i;
    end
  end

  // captured request
  logic [BOX_W-1:0] box_a_q, box_b_q;
  logic [IDX_W-1:0] a_q, b_q;
  logic             ok_q;

  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      box_a_q <= in_box_a;
      box_b_q <= in_box_b;
      a_q     <= a_idx;
      b_q     <= b_idx;
      ok_q    <= a_rng && b_rng && (in_box_a != in_box_b);
    end
  end

  // geometry memory, one write and two read ports
  geom_t gmem [NUM_BOXES];
  geom_t geo_a_q, geo_b_q;
  logic  gw_en;
  logic  g_re;

  always_ff @(posedge clk_i) begin
    if (gw_en) begin
      gmem[a_idx] <= in_geom;
    end
    if (g_re) begin
      geo_a_q <= gmem[a_idx];
      geo_b_q <= gmem[b_idx];
    end
  end

  // contact row memory, one write and two read ports
  logic [NUM_BOXES-1:0] cmem [NUM_BOXES];
  logic [NUM_BOXES-1:0] crd_a_q, crd_b_q;
  logic                 cvld_a_q, cvld_b_q;
  logic [NUM_BOXES-1:0] row_vld_q, row_vld_d;
  logic                 cw_en;
  logic [IDX_W-1:0]     cw_addr;
  logic [NUM_BOXES-1:0] cw_data;
  logic                 cr_a_en, cr_b_en;
  logic [IDX_W-1:0]     cr_a_addr;

  always_ff @(posedge clk_i) begin
    if (cw_en) begin
      cmem[cw_addr] <= cw_data;
    end
    if (cr_a_en) begin
      crd_a_q  <= cmem[cr_a_addr];
      cvld_a_q <= row_vld_q[cr_a_addr];
    end
    if (cr_b_en) begin
      crd_b_q  <= cmem[b_idx];
      cvld_b_q <= row_vld_q[b_idx];
    end
  end

  logic [NUM_BOXES-1:0] row_a_eff, row_b_eff;

  // a row never written since reset reads as no contacts
  assign row_a_eff = cvld_a_q ? crd_a_q : '0;
  assign row_b_eff = cvld_b_q ? crd_b_q : '0;

  // active flags
  logic [NUM_BOXES-1:0] act_q, act_d;

  // pair evaluation, |d| <= t tested as d <= t and -d <= t
  logic signed [16:0] dz_ab, dz_ba, thr_s;
  logic signed [17:0] dx_ab, dx_ba, dy_ab, dy_ba, sw, sh;
  logic               overlap;
  logic               both_act;
  logic               old_bit, new_bit;
  logic               new_bit_q, new_bit_d;
  logic [1:0]         chk_ev;

  assign dz_ab = {geo_a_q.z[15], geo_a_q.z} - {geo_b_q.z[15], geo_b_q.z};
  assign dz_ba = {geo_b_q.z[15], geo_b_q.z} - {geo_a_q.z[15], geo_a_q.z};
  assign thr_s = {1'b0, z_thr_q};
  assign dx_ab = {geo_a_q.x[15], geo_a_q.x, 1'b0} - {geo_b_q.x[15], geo_b_q.x, 1'b0};
  assign dx_ba = {geo_b_q.x[15], geo_b_q.x, 1'b0} - {geo_a_q.x[15], geo_a_q.x, 1'b0};
  assign dy_ab = {geo_a_q.y[15], geo_a_q.y, 1'b0} - {geo_b_q.y[15], geo_b_q.y, 1'b0};
  assign dy_ba = {geo_b_q.y[15], geo_b_q.y, 1'b0} - {geo_a_q.y[15], geo_a_q.y, 1'b0};
  assign sw    = {6'd0, geo_a_q.w} + {6'd0, geo_b_q.w};
  assign sh    = {6'd0, geo_a_q.h} + {6'd0, geo_b_q.h};

  assign overlap = (dz_ab <= thr_s) && (dz_ba <= thr_s)
                && (dx_ab <= sw) && (dx_ba <= sw)
                && (dy_ab <= sh) && (dy_ba <= sh);
  assign both_act = act_q[a_q] && act_q[b_q];
  assign old_bit  = row_a_eff[b_q];

  always_comb begin
    new_bit = old_bit;
    chk_ev  = EV_NONE;
    if (ok_q) begin
      if (!both_act) begin
        new_bit = 1'b0;
      end else if (overlap) begin
        new_bit = 1'b1;
        chk_ev  = old_bit ? EV_NONE : EV_ENTER;
      end else begin
        new_bit = 1'b0;
        chk_ev  = old_bit ? EV_EXIT : EV_NONE;
      end
    end
  end

  // disable walk
  logic [NUM_BOXES-1:0] pend_q, pend_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d;
  logic [6:0]           cnt_ext;

  assign cnt_ext = 7'(cnt_q);

  // output register
  logic             m_valid_q, m_valid_d;
  logic [1:0]       m_ev_q;
  logic [BOX_W-1:0] m_first_q, m_second_q;
  logic             m_last_q;
  logic             out_free;
  logic             out_load;
  logic [1:0]       out_ev;
  logic [BOX_W-1:0] out_second;
  logic             out_last;

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    row_vld_d  = row_vld_q;
    new_bit_d  = new_bit_q;
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    gw_en      = 1'b0;
    g_re       = 1'b0;
    cw_en      = 1'b0;
    cw_addr    = a_q;
    cw_data    = '0;
    cr_a_en    = 1'b0;
    cr_b_en    = 1'b0;
    cr_a_addr  = a_idx;
    out_load   = 1'b0;
    out_ev     = EV_NONE;
    out_second = box_b_q;
    out_last   = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (in_hs) begin
          case (s_axis_tuser)
            MODE_WRITE: begin
              if (a_rng) begin
                gw_en        = 1'b1;
                act_d[a_idx] = in_active;
              end
            end
            MODE_CHECK: begin
              g_re    = 1'b1;
              cr_a_en = 1'b1;
              cr_b_en = 1'b1;
              state_d = ST_CHECK;
            end
            MODE_DISABLE: begin
              if (a_rng && act_q[a_idx]) begin
                act_d[a_idx] = 1'b0;
                cr_a_en      = 1'b1;
                state_d      = ST_DIS_LOAD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_CHECK: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_ev    = chk_ev;
          new_bit_d = new_bit;
          if (ok_q && (new_bit != old_bit)) begin
            cw_en            = 1'b1;
            cw_addr          = a_q;
            cw_data          = row_a_eff;
            cw_data[b_q]     = new_bit;
            row_vld_d[a_q]   = 1'b1;
            state_d          = ST_WRB;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      // mirror entry of the symmetric matrix
      ST_WRB: begin
        cw_en          = 1'b1;
        cw_addr        = b_q;
        cw_data        = row_b_eff;
        cw_data[a_q]   = new_bit_q;
        row_vld_d[b_q] = 1'b1;
        state_d        = ST_IDLE;
      end

      ST_DIS_LOAD: begin
        pend_d         = row_a_eff & ~(ROW_ONE << a_q);
        cw_en          = 1'b1;
        cw_addr        = a_q;
        cw_data        = '0;
        row_vld_d[a_q] = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIS_SCAN;
      end

      ST_DIS_SCAN: begin
        if (pend_q == '0) begin
          state_d = ST_IDLE;
        end else if (pend_q[cnt_q]) begin
          cr_a_en   = 1'b1;
          cr_a_addr = cnt_q;
          state_d   = ST_DIS_RMW;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_DIS_RMW: begin
        if (out_free) begin
          pend_d[cnt_q]    = 1'b0;
          out_load         = 1'b1;
          out_ev           = EV_EXIT;
          out_second       = cnt_ext[BOX_W-1:0];
          out_last         = (pend_d == '0);
          cw_en            = 1'b1;
          cw_addr          = cnt_q;
          cw_data          = row_a_eff & ~(ROW_ONE << a_q);
          row_vld_d[cnt_q] = 1'b1;
          cnt_d            = cnt_q + 1'b1;
          state_d          = ST_DIS_SCAN;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    m_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      act_q     <= '0;
      row_vld_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      act_q     <= act_d;
      row_vld_q <= row_vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_bit_q <= new_bit_d;
    pend_q    <= pend_d;
    cnt_q     <= cnt_d;
    if (out_load) begin
      m_ev_q     <= out_ev;
      m_first_q  <= box_a_q;
      m_second_q <= out_second;
      m_last_q   <= out_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, m_second_q, m_first_q};
  assign m_axis_tuser  = m_ev_q;
  assign m_axis_tlast  = m_last_q;

  // a box being disabled is already inactive while its partners are walked
  `BCT_ASSERT_NOW(a_dis_inactive, state_q == ST_DIS_SCAN, !act_q[a_q],
    "disabled box still active during partner walk")

  // the disabled box never appears as its own partner
  `BCT_ASSERT_NOW(a_dis_no_self, state_q == ST_DIS_SCAN || state_q == ST_DIS_RMW,
    !pend_q[a_q], "disabled box pending as its own partner")

  // a partner row is only rewritten for a pending partner
  `BCT_ASSERT_NOW(a_rmw_pending, state_q == ST_DIS_RMW, pend_q[cnt_q],
    "partner update without pending contact")

  // the mirror write always follows a pair evaluation
  `BCT_ASSERT_NOW(a_wrb_after_check, state_q == ST_WRB, $past(state_q) == ST_CHECK,
    "mirror row write outside a pair check")

  // an enter event never names a box paired with itself
  `BCT_ASSERT_NOW(a_enter_pair, m_axis_tvalid && m_axis_tuser == EV_ENTER,
    m_first_q != m_second_q, "contact began on a self pair")

endmodule

[sim/box_contact_tracker_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_contact_tracker_tb
// Self-checking bench for the box contact tracker. A table of directed
// requests covers box writes, pair checks and disables at the field extremes
// and on the depth-threshold edge. Random phases follow, each at its own
// depth threshold. A model of the box table and the contact matrix predicts
// every event, and each event on m_axis is checked against it in order.
// ----------------------------------------------------------------------------
module box_contact_tracker_tb;
  import bct_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int NBOX         = 32;
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 35;
  localparam int IDLE_PCT     = 22;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [BOX_W-1:0]   a;
    logic [BOX_W-1:0]   b;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
    logic               act;
  } req_t;

  typedef struct packed {
    logic [1:0]       ev;
    logic [BOX_W-1:0] first;
    logic [BOX_W-1:0] second;
    logic             last;
  } evt_t;

  typedef struct {
    req_t       rq;
    bit         fixed;
    logic [1:0] fev;
  } stim_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  box_contact_tracker #(
    .NUM_BOXES(NBOX)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // model state: box table, active flags, contact matrix, depth threshold
  logic signed [COORD_W-1:0] geo_x [NBOX];
  logic signed [COORD_W-1:0] geo_y [NBOX];
  logic signed [COORD_W-1:0] geo_z [NBOX];
  logic [SIZE_W-1:0]         geo_w [NBOX];
  logic [SIZE_W-1:0]         geo_h [NBOX];
  bit                        box_on [NBOX];
  logic [NBOX-1:0]           touching [NBOX];
  int unsigned               z_limit;

  evt_t      pending_events[$];
  stim_row_t dir_tab[$];

  bit steady_phase = 1'b0;
  int err_cnt      = 0;
  int n_req        = 0;
  int n_chk        = 0;
  int n_dis        = 0;
  int n_evt        = 0;
  int n_enter      = 0;
  int n_exit       = 0;
  int stall_cnt    = 0;

  function automatic int unsigned span(input int p, input int q);
    return (p >= q) ? p - q : q - p;
  endfunction

  function automatic void add_row(input stim_row_t t);
    dir_tab = {dir_tab, t};
  endfunction

  task automatic track_contacts(input req_t r, input bit use_fixed,
                                input logic [1:0] fixed_ev);
    logic [1:0]  ev;
    bit          hit;
    int          last_p;
    int unsigned ia;
    int unsigned ib;
    evt_t        e;
    ia = r.a;
    ib = r.b;
    case (r.mode)
      MODE_WRITE: begin
        geo_x[ia]  = r.x;
        geo_y[ia]  = r.y;
        geo_z[ia]  = r.z;
        geo_w[ia]  = r.w;
        geo_h[ia]  = r.h;
        box_on[ia] = r.act;
      end
      MODE_CHECK: begin
        ev = EV_NONE;
        if (ia != ib) begin
          if (!box_on[ia] || !box_on[ib]) begin
            touching[ia][ib] = 1'b0;
            touching[ib][ia] = 1'b0;
          end else begin
            hit = span(geo_z[ia], geo_z[ib]) <= z_limit
               && 2 * span(geo_x[ia], geo_x[ib]) <= int'(geo_w[ia]) + int'(geo_w[ib])
               && 2 * span(geo_y[ia], geo_y[ib]) <= int'(geo_h[ia]) + int'(geo_h[ib]);
            if (hit && !touching[ia][ib]) begin
              touching[ia][ib] = 1'b1;
              touching[ib][ia] = 1'b1;
              ev = EV_ENTER;
            end else if (!hit && touching[ia][ib]) begin
              touching[ia][ib] = 1'b0;
              touching[ib][ia] = 1'b0;
              ev = EV_EXIT;
            end
          end
        end
        if (use_fixed) ev = fixed_ev;
        e.ev     = ev;
        e.first  = r.a;
        e.second = r.b;
        e.last   = 1'b1;
        pending_events = {pending_events, e};
      end
      MODE_DISABLE: begin
        if (box_on[ia]) begin
          box_on[ia] = 1'b0;
          last_p = -1;
          for (int i = 0; i < NBOX; i++) begin
            if (i != ia && touching[ia][i]) last_p = i;
          end
          // one exit per partner, ascending, tlast on the highest
          for (int i = 0; i < NBOX; i++) begin
            if (i != ia && touching[ia][i]) begin
              e.ev     = EV_EXIT;
              e.first  = r.a;
              e.second = BOX_W'(i);
              e.last   = (i == last_p);
              pending_events = {pending_events, e};
            end
            touching[ia][i] = 1'b0;
            touching[i][ia] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_req(input req_t r, input bit use_fixed, input logic [1:0] fixed_ev);
    while (!steady_phase && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.mode;
    s_axis_tdata  <= {5'd0, r.act, r.h, r.w, r.z, r.y, r.x, r.b, r.a};
    do @(posedge clk_i); while (!s_axis_tready);
    n_req++;
    if (r.mode == MODE_CHECK) n_chk++;
    if (r.mode == MODE_DISABLE) n_dis++;
    track_contacts(r, use_fixed, fixed_ev);
  endtask

  // block goes quiet: all events back, then room for a disable scan that gave none
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    z_limit = v;
  endtask

  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) r.mode = MODE_WRITE;
    else if (pick < 80) r.mode = MODE_CHECK;
    else if (pick < 94) r.mode = MODE_DISABLE;
    else r.mode = MODE_UNUSED;
    // most traffic on a few boxes so contacts build up
    r.a = ($urandom_range(0, 9) < 7) ? BOX_W'($urandom_range(0, 7))
                                     : BOX_W'($urandom_range(0, NBOX - 1));
    r.b = ($urandom_range(0, 9) < 7) ? BOX_W'($urandom_range(0, 7))
                                     : BOX_W'($urandom_range(0, NBOX - 1));
    if ($urandom_range(0, 4) == 0) begin
      r.x = COORD_W'($urandom);
      r.y = COORD_W'($urandom);
      r.z = COORD_W'($urandom);
      r.w = SIZE_W'($urandom);
      r.h = SIZE_W'($urandom);
    end else begin
      r.x = COORD_W'($urandom_range(0, 600) - 300);
      r.y = COORD_W'($urandom_range(0, 600) - 300);
      r.z = COORD_W'($urandom_range(0, 4) * 10);
      r.w = SIZE_W'($urandom_range(0, 800));
      r.h = SIZE_W'($urandom_range(0, 800));
    end
    r.act = ($urandom_range(0, 9) != 0);
    return r;
  endfunction

  task automatic random_phase(input int n_items);
    req_t r;
    int   sent;
    sent = 0;
    while (sent < n_items) begin
      r = random_request();
      send_req(r, 1'b0, EV_NONE);
      if (r.mode != MODE_UNUSED) sent++;
    end
  endtask

  function automatic stim_row_t mk_row(input logic [1:0] mode, input int a, input int b,
                                       input int x, input int y, input int z,
                                       input int w, input int h, input bit act,
                                       input bit fixed, input logic [1:0] fev);
    stim_row_t t;
    t.rq.mode = mode;
    t.rq.a    = a[BOX_W-1:0];
    t.rq.b    = b[BOX_W-1:0];
    t.rq.x    = x[COORD_W-1:0];
    t.rq.y    = y[COORD_W-1:0];
    t.rq.z    = z[COORD_W-1:0];
    t.rq.w    = w[SIZE_W-1:0];
    t.rq.h    = h[SIZE_W-1:0];
    t.rq.act  = act;
    t.fixed   = fixed;
    t.fev     = fev;
    return t;
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= steady_phase || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  evt_t seen;
  evt_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.ev     = m_axis_tuser;
      seen.first  = m_axis_tdata[BOX_W-1:0];
      seen.second = m_axis_tdata[2*BOX_W-1:BOX_W];
      seen.last   = m_axis_tlast;
      n_evt++;
      if (seen.ev == EV_ENTER) n_enter++;
      if (seen.ev == EV_EXIT) n_exit++;
      if (pending_events.size() == 0) begin
        flag_error($sformatf("unexpected event ev=%0d pair %0d/%0d last=%0d",
                             seen.ev, seen.first, seen.second, seen.last));
      end else begin
        want = pending_events.pop_front();
        if (seen.ev !== want.ev || seen.first !== want.first
            || seen.second !== want.second || seen.last !== want.last) begin
          flag_error($sformatf(
            "event %0d: expected ev=%0d pair %0d/%0d last=%0d, got ev=%0d pair %0d/%0d last=%0d",
            n_evt, want.ev, want.first, want.second, want.last,
            seen.ev, seen.first, seen.second, seen.last));
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles, %0d events outstanding",
               STALL_LIMIT, pending_events.size());
      $display("box_contact_tracker_tb: done, errors");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    req_t      r;
    int        mid_thr;
    for (int i = 0; i < NBOX; i++) begin
      box_on[i]   = 1'b0;
      touching[i] = '0;
    end
    z_limit = Z_THR_RESET;

    //             mode          a   b       x       y       z     w     h act fix expected
    add_row(mk_row(MODE_WRITE,    0,  0,      0,      0,      0,  100,  100, 1, 0, EV_NONE));
    add_row(mk_row(MODE_WRITE,    1,  0,     50,     50,     25,    0,    0, 1, 0, EV_NONE));
    // depth exactly at the reset threshold, x touching edge to edge
    add_row(mk_row(MODE_CHECK,    0,  1,      0,      0,      0,    0,    0, 0, 1, EV_ENTER));
    add_row(mk_row(MODE_CHECK,    1,  0,      0,      0,      0,    0,    0, 0, 1, EV_NONE));
    add_row(mk_row(MODE_CHECK,    0,  0,      0,      0,      0,    0,    0, 0, 1, EV_NONE));
    add_row(mk_row(MODE_WRITE,    1,  0,     51,     50,     25,    0,    0, 1, 0, EV_NONE));
    add_row(mk_row(MODE_CHECK,    0,  1,      0,      0,      0,    0,    0, 0, 1, EV_EXIT));
    add_row(mk_row(MODE_CHECK,    0,  1,      0,      0,      0,    0,    0, 0, 1, EV_NONE));
    // one past the threshold
    add_row(mk_row(MODE_WRITE,    1,  0,     50,     50,     26,    0,    0, 1, 0, EV_NONE));
    add_row(mk_row(MODE_CHECK,    0,  1,      0,      0,      0,    0,    0, 0, 1, EV_NONE));
    add_row(mk_row(MODE_WRITE,    1,  0,    -50,    -50,    -25,    0,    0, 1, 0, EV_NONE));
    add_row(mk_row(MODE_CHECK,    1,  0,      0,      0,      0,    0,    0, 0, 1, EV_ENTER));
    add_row(mk_row(MODE_WRITE,    2, 31, -32768,  32767, -32768, 4095, 4095, 1, 0, EV_NONE));
    add_row(mk_row(MODE_WRITE,    3, 31,  32767, -32768,  32767, 4095, 4095, 1, 0, EV_NONE));
    add_row(mk_row(MODE_CHECK,    2,  3,      0,      0,      0,    0,    0, 0, 1, EV_NONE));
    add_row(mk_row(MODE_WRITE,   31,  0,    -50,    -50,      0, 4095, 4095, 1, 0, EV_NONE));
    add_row(mk_row(MODE_CHECK,   31,  0,      0,      0,      0,    0,    0, 0, 1, EV_ENTER));
    add_row(mk_row(MODE_CHECK,    1, 31,      0,      0,      0,    0,    0, 0, 1, EV_ENTER));
    // box 0 leaves with two partners in contact
    add_row(mk_row(MODE_DISABLE,  0, 31,     -1,     -1,     -1, 4095, 4095, 1, 0, EV_NONE));
    add_row(mk_row(MODE_DISABLE,  0,  0,      0,      0,      0,    0,    0, 0, 0, EV_NONE));
    add_row(mk_row(MODE_CHECK,    0,  1,      0,      0,      0,    0,    0, 0, 1, EV_NONE));
    add_row(mk_row(MODE_UNUSED,  31, 31,     -1,     -1,     -1, 4095, 4095, 1, 0, EV_NONE));
    // inactive write keeps the contact until the next check clears it silently
    add_row(mk_row(MODE_WRITE,    1,  0,    -50,    -50,    -25,    0,    0, 0, 0, EV_NONE));
    add_row(mk_row(MODE_CHECK,    1, 31,      0,      0,      0,    0,    0, 0, 1, EV_NONE));
    add_row(mk_row(MODE_DISABLE, 31,  0,      0,      0,      0,    0,    0, 0, 0, EV_NONE));
    add_row(mk_row(MODE_CHECK,    2, 31,      0,      0,      0,    0,    0, 0, 1, EV_NONE));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[k]) send_req(dir_tab[k].rq, dir_tab[k].fixed, dir_tab[k].fev);

    // depth must match exactly; every box gets geometry first
    settle();
    set_threshold('0);
    for (int i = 0; i < NBOX; i++) begin
      r      = random_request();
      r.mode = MODE_WRITE;
      r.a    = BOX_W'(i);
      send_req(r, 1'b0, EV_NONE);
    end
    random_phase(PHASE_ITEMS);

    // widest threshold, both sides without idle cycles
    settle();
    set_threshold('1);
    steady_phase = 1'b1;
    random_phase(PHASE_ITEMS);
    steady_phase = 1'b0;

    settle();
    mid_thr = $urandom_range(5, 35);
    set_threshold(THR_W'(mid_thr));
    random_phase(PHASE_ITEMS);

    settle();
    set_threshold(Z_THR_RESET);
    random_phase(PHASE_ITEMS);

    settle();
    $display("covered %0d requests (%0d pair checks, %0d disables), %0d events: %0d enters, %0d exits",
             n_req, n_chk, n_dis, n_evt, n_enter, n_exit);
    $display("depth thresholds 25, 0, 65535, %0d, 25; %0d mismatches", mid_thr, err_cnt);
    if (err_cnt == 0) begin
      $display("box_contact_tracker_tb: done, clean");
    end else begin
      $display("box_contact_tracker_tb: done, errors");
    end
    $finish;
  end

endmodule
